// ===== rtl/core/psfe_pkg.sv =====
`timescale 1ns / 1ps
package psfe_pkg;

  localparam int unsigned OP_LOAD = 0;
  localparam int unsigned OP_EVAL = 1;

  localparam logic [1:0] CFG_FIT_MODE    = 2'd0;
  localparam logic [1:0] CFG_POLY_DEGREE = 2'd1;
  localparam logic [1:0] CFG_KNOT_COUNT  = 2'd2;
  localparam logic [1:0] CFG_INV_MEAN    = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [5:0]         row_index;
    logic signed [31:0] knot_position;
    logic signed [31:0] knot_value;
    logic signed [31:0] slope_linear;
    logic signed [31:0] slope_quadratic;
    logic signed [31:0] slope_cubic;
    logic [23:0]        wave;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] flux;
    logic               saturated;
  } out_item_t;

  // evaluate job handed from front to back
  typedef struct packed {
    logic signed [31:0] x;
    logic               sat;
  } job_t;

  // 36 bits hold a full 32x32 product shifted by 28 plus a 32-bit addend
  function automatic logic signed [31:0] clip32(input logic signed [35:0] v,
                                                 output logic hit);
    logic signed [31:0] r;
    hit = 1'b0;
    r = v[31:0];
    if (v > 36'sd2147483647) begin
      hit = 1'b1;
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      hit = 1'b1;
      r = 32'sh80000000;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/psfe_front.sv =====
`timescale 1ns / 1ps
// Front: takes items, does loads, computes normalised x for evaluates.
module psfe_front #(
  parameter int MAX_KNOTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  psfe_pkg::in_item_t  in_item,
  input  logic [31:0]         inv_mean,
  output logic                ld_we,
  output logic [5:0]          ld_row,
  output psfe_pkg::in_item_t  ld_item,
  output logic                job_valid,
  output psfe_pkg::job_t      job,
  input  logic                job_full,
  input  logic                eval_busy
);
  logic        busy_r, busy_nxt;
  logic [55:0] prod_r;
  logic        acc;

  assign acc = in_push && !in_full;
  // a load waits until no evaluate is left to read the tables
  assign in_full = busy_r || job_full ||
                   (eval_busy && (in_item.operation == 1'(psfe_pkg::OP_LOAD)));

  // loads: row_index is 6 bits, rows at or above MAX_KNOTS ignored
  assign ld_we   = acc && (in_item.operation == 1'(psfe_pkg::OP_LOAD)) &&
                   ({26'd0, in_item.row_index} < 32'(MAX_KNOTS));
  assign ld_row  = in_item.row_index;
  assign ld_item = in_item;

  assign busy_nxt = acc && (in_item.operation == 1'(psfe_pkg::OP_EVAL));

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
    if (busy_nxt) prod_r <= {32'd0, in_item.wave} * {24'd0, inv_mean};
  end

  assign job_valid = busy_r;
  always_comb begin
    if (prod_r[55:51] != 5'd0) begin
      job.x = 32'sh7FFFFFFF;
      job.sat = 1'b1;
    end else begin
      job.x = prod_r[51:20];
      job.sat = 1'b0;
    end
  end
endmodule

// ===== rtl/core/psfe_queue.sv =====
`timescale 1ns / 1ps
// Short job queue between front and back.
module psfe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr,
  input  psfe_pkg::job_t  wdata,
  output logic            full,
  input  logic            rd,
  output logic            valid,
  output psfe_pkg::job_t  rdata
);
  psfe_pkg::job_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr && !full) wp_r <= ~wp_r;
      if (rd && valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr && !full) - 2'(rd && valid);
    end
    if (wr && !full) mem_r[wp_r] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr && full)) else $error("job queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |=> !(cnt_r == 2'd2)) else $error("queue jumped");
endmodule

// ===== rtl/core/psfe_back.sv =====
`timescale 1ns / 1ps
// Back: tables, knot search, shared multiply-add, output register.
module psfe_back #(
  parameter int MAX_KNOTS  = 64,
  parameter int MAX_DEGREE = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld_we,
  input  logic [5:0]          ld_row,
  input  psfe_pkg::in_item_t  ld_item,
  input  logic                job_valid,
  input  psfe_pkg::job_t      job,
  output logic                job_pop,
  output logic                busy,
  input  logic                fit_mode,
  input  logic [3:0]          poly_degree,
  input  logic [6:0]          knot_count,
  output logic                out_empty,
  input  logic                out_pop,
  output psfe_pkg::out_item_t out_item
);
  localparam int AW = $clog2(MAX_KNOTS);
  localparam int DCAP = (MAX_DEGREE < MAX_KNOTS - 1) ? MAX_DEGREE : MAX_KNOTS - 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SRCH  = 10'b0000000010,
    S_SRCHW = 10'b0000000100,
    S_SEG   = 10'b0000001000,
    S_DX    = 10'b0000010000,
    S_MUL   = 10'b0000100000,
    S_ADD   = 10'b0001000000,
    S_PINIT = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_RDW   = 10'b1000000000
  } st_t;

  logic signed [31:0] tx_r [MAX_KNOTS];
  logic signed [31:0] ty_r [MAX_KNOTS];
  logic signed [31:0] tl_r [MAX_KNOTS];
  logic signed [31:0] tq_r [MAX_KNOTS];
  logic signed [31:0] tc_r [MAX_KNOTS];

  st_t st_r;
  logic [AW-1:0] ra_r;
  logic signed [31:0] rx_r, ry_r, rl_r, rq_r, rc_r;
  logic [AW:0]   i_r, n_r;
  logic [AW-1:0] seg_r;
  logic [5:0]    k_r;
  logic [1:0]    step_r;
  logic signed [31:0] x_r, acc_r, mulb_r;
  logic signed [63:0] prod_r;
  logic          flag_r, outv_r;
  logic signed [31:0] oflux_r;
  logic          osat_r;

  logic signed [31:0] addend;
  logic signed [35:0] sum;
  logic signed [31:0] clipped;
  logic               hit;
  logic signed [31:0] dxc;
  logic               dxhit;
  logic [6:0]         ncl;
  logic [5:0]         degc;

  always_ff @(posedge clk) begin
    if (ld_we) begin
      tx_r[AW'(ld_row)] <= ld_item.knot_position;
      ty_r[AW'(ld_row)] <= ld_item.knot_value;
      tl_r[AW'(ld_row)] <= ld_item.slope_linear;
      tq_r[AW'(ld_row)] <= ld_item.slope_quadratic;
      tc_r[AW'(ld_row)] <= ld_item.slope_cubic;
    end
    rx_r <= tx_r[ra_r];
    ry_r <= ty_r[ra_r];
    rl_r <= tl_r[ra_r];
    rq_r <= tq_r[ra_r];
    rc_r <= tc_r[ra_r];
  end

  always_comb begin
    ncl = knot_count;
    if (ncl < 7'd2) ncl = 7'd2;
    if (32'(ncl) > 32'(MAX_KNOTS)) ncl = 7'(MAX_KNOTS);
    degc = {2'd0, poly_degree};
    if (32'(degc) > 32'(DCAP)) degc = 6'(DCAP);
  end

  // spline step order: cubic*dx+quad, *dx+lin, *dx+y
  always_comb begin
    if (fit_mode) begin
      case (step_r)
        2'd0: addend = rq_r;
        2'd1: addend = rl_r;
        default: addend = ry_r;
      endcase
    end else begin
      addend = ry_r;
    end
    sum = 36'(prod_r >>> 28) + 36'(addend);
    clipped = psfe_pkg::clip32(36'(prod_r >>> 28) + 36'(addend), hit);
    dxc = psfe_pkg::clip32(36'(x_r) - 36'(rx_r), dxhit);
  end

  assign job_pop   = (st_r == S_IDLE) && job_valid && !outv_r;
  assign busy      = st_r != S_IDLE;
  assign out_empty = !outv_r;
  assign out_item.flux = oflux_r;
  assign out_item.saturated = osat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      outv_r <= 1'b0;
    end else begin
      if (out_pop && outv_r) outv_r <= 1'b0;
      case (st_r)
        S_IDLE: if (job_pop) begin
          x_r <= job.x;
          flag_r <= job.sat;
          if (fit_mode) begin
            ra_r <= '0;
            i_r <= '0;
            n_r <= (AW+1)'(ncl);
            seg_r <= '0;
            st_r <= S_SRCH;
          end else begin
            ra_r <= AW'(degc);
            k_r <= degc;
            st_r <= S_RDW;
          end
        end
        S_RDW: begin
          // table read is registered: let the new address land
          if (fit_mode) st_r <= S_DX;
          else st_r <= S_PINIT;
        end
        S_PINIT: begin
          acc_r <= ry_r;
          mulb_r <= x_r;
          if (k_r == 6'd0) st_r <= S_DONE;
          else begin
            ra_r <= ra_r - 1'b1;
            st_r <= S_MUL;
          end
        end
        S_SRCH: begin
          // address issued, data next cycle
          i_r <= i_r + 1'b1;
          ra_r <= ra_r + 1'b1;
          st_r <= S_SRCHW;
        end
        S_SRCHW: begin
          if (x_r >= rx_r) seg_r <= i_r[AW-1:0] - 1'b1;
          if (i_r == n_r) begin
            st_r <= S_SEG;
          end else begin
            i_r <= i_r + 1'b1;
            ra_r <= ra_r + 1'b1;
          end
        end
        S_SEG: begin
          if ({1'b0, seg_r} == n_r - 1'b1) begin
            ra_r <= seg_r - 1'b1;
            seg_r <= seg_r - 1'b1;
          end else begin
            ra_r <= seg_r;
          end
          st_r <= S_RDW;
        end
        S_DX: begin
          mulb_r <= dxc;
          flag_r <= flag_r | dxhit;
          acc_r <= rc_r;
          step_r <= 2'd0;
          st_r <= S_MUL;
        end
        S_MUL: begin
          prod_r <= 64'(acc_r) * 64'(mulb_r);
          st_r <= S_ADD;
        end
        S_ADD: begin
          acc_r <= clipped;
          flag_r <= flag_r | hit;
          if (fit_mode) begin
            if (step_r == 2'd2) st_r <= S_DONE;
            else begin
              step_r <= step_r + 1'b1;
              st_r <= S_MUL;
            end
          end else begin
            k_r <= k_r - 1'b1;
            if (k_r == 6'd1) st_r <= S_DONE;
            else begin
              ra_r <= ra_r - 1'b1;
              st_r <= S_MUL;
            end
          end
        end
        S_DONE: begin
          oflux_r <= acc_r;
          osat_r <= flag_r;
          outv_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> st_r != S_IDLE) else $error("job taken but not started");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DONE |=> outv_r) else $error("result not posted");
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DONE |-> !outv_r || out_pop) else $error("result overwritten");
  a_sum_used: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ADD && !hit) |-> sum[31:0] == clipped) else $error("clip mismatch");
endmodule

// ===== rtl/core/poly_or_spline_fit_evaluator_unit.sv =====
`timescale 1ns / 1ps
// Fitted-curve evaluator. Load items write one table row when they are taken
// and give no result; a load is held off while an evaluate is still queued
// or running, so a row never changes under an evaluation. An evaluate item
// runs a Horner loop over poly_degree in polynomial mode and, in spline
// mode, a linear knot search over knot_count knots (clamped to
// 2..MAX_KNOTS) and then the cubic steps; one 32x32 multiplier is shared by
// all Horner and cubic steps, and the table read is registered and
// single-port. A two-entry job queue sits between the input stage and the
// evaluator; the output register holds a result until popped.
module poly_or_spline_fit_evaluator_unit #(
  parameter int MAX_KNOTS  = 64,
  parameter int MAX_DEGREE = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  psfe_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output psfe_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  logic        fit_mode_r;
  logic [3:0]  poly_degree_r;
  logic [6:0]  knot_count_r;
  logic [31:0] inv_mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= 1'b0;
      poly_degree_r <= 4'd0;
      knot_count_r <= 7'd2;
      inv_mean_r <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        psfe_pkg::CFG_FIT_MODE:    fit_mode_r <= cfg_wdata[0];
        psfe_pkg::CFG_POLY_DEGREE: poly_degree_r <= cfg_wdata[3:0];
        psfe_pkg::CFG_KNOT_COUNT:  knot_count_r <= cfg_wdata[6:0];
        psfe_pkg::CFG_INV_MEAN:    inv_mean_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic               ld_we;
  logic [5:0]         ld_row;
  psfe_pkg::in_item_t ld_item;
  logic               fj_valid, q_full, q_valid, q_pop;
  logic               back_busy, eval_busy;
  psfe_pkg::job_t     fj, qj;

  assign eval_busy = q_valid || back_busy;

  psfe_front #(.MAX_KNOTS(MAX_KNOTS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item,
    .inv_mean(inv_mean_r), .ld_we, .ld_row, .ld_item,
    .job_valid(fj_valid), .job(fj), .job_full(q_full),
    .eval_busy(eval_busy)
  );

  psfe_queue u_queue (
    .clk, .rst_n, .wr(fj_valid), .wdata(fj), .full(q_full),
    .rd(q_pop), .valid(q_valid), .rdata(qj)
  );

  psfe_back #(.MAX_KNOTS(MAX_KNOTS), .MAX_DEGREE(MAX_DEGREE)) u_back (
    .clk, .rst_n, .ld_we, .ld_row, .ld_item,
    .job_valid(q_valid), .job(qj), .job_pop(q_pop), .busy(back_busy),
    .fit_mode(fit_mode_r), .poly_degree(poly_degree_r),
    .knot_count(knot_count_r), .out_empty, .out_pop, .out_item
  );
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int N_ROWS = 64;
  localparam int SETTLE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  psfe_pkg::in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  psfe_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  poly_or_spline_fit_evaluator_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the block's registers and tables
  logic        mode_r;
  logic [3:0]  degree_r;
  logic [6:0]  knots_r;
  logic [31:0] inv_mean_r;
  logic signed [31:0] kx [N_ROWS];
  logic signed [31:0] ky [N_ROWS];
  logic signed [31:0] c1 [N_ROWS];
  logic signed [31:0] c2 [N_ROWS];
  logic signed [31:0] c3 [N_ROWS];

  psfe_pkg::in_item_t  pending_items[$];
  psfe_pkg::out_item_t expected_flux[$];
  bit in_taken = 0, out_taken = 0;
  int send_gap = 0, pop_gap = 0;
  int idle_cycles = 0;
  int errors = 0;

  function automatic logic signed [31:0] sat32(longint v, inout bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1;
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      hit = 1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // a (Q16.16) * b (Q4.28) >> 28 floored, plus c
  function automatic logic signed [31:0] fma_q28(logic signed [31:0] a,
      logic signed [31:0] b, logic signed [31:0] c, inout bit hit);
    longint p;
    p = (longint'(a) * longint'(b)) >>> 28;
    return sat32(p + longint'(c), hit);
  endfunction

  function automatic psfe_pkg::out_item_t eval_curve(logic [23:0] wave);
    bit hit;
    longint unsigned xn;
    logic signed [31:0] x, acc, dx, t;
    int n, seg;
    psfe_pkg::out_item_t r;
    hit = 0;
    xn = (longint'(wave) * longint'(inv_mean_r)) >> 20;
    if (xn > 64'h7FFFFFFF) begin
      xn = 64'h7FFFFFFF;
      hit = 1;
    end
    x = xn[31:0];
    if (mode_r == 1'b0) begin
      acc = ky[degree_r];
      for (int k = degree_r; k >= 1; k--) acc = fma_q28(acc, x, ky[k-1], hit);
    end else begin
      n = knots_r;
      if (n < 2) n = 2;
      if (n > N_ROWS) n = N_ROWS;
      seg = 0;
      for (int i = 0; i < n; i++) if (x >= kx[i]) seg = i;
      if (seg == n - 1) seg = n - 2;
      dx = sat32(longint'(x) - longint'(kx[seg]), hit);
      t = fma_q28(c3[seg], dx, c2[seg], hit);
      t = fma_q28(t, dx, c1[seg], hit);
      acc = fma_q28(t, dx, ky[seg], hit);
    end
    r.flux = acc;
    r.saturated = hit;
    return r;
  endfunction

  // monitor: predict on accepted items, check accepted results
  always @(posedge clk) begin
    psfe_pkg::out_item_t exp_r;
    if (rst_n) begin
      if (in_push && !in_full) begin
        in_taken = 1;
        if (in_item.operation == 1'(psfe_pkg::OP_LOAD)) begin
          kx[in_item.row_index] = in_item.knot_position;
          ky[in_item.row_index] = in_item.knot_value;
          c1[in_item.row_index] = in_item.slope_linear;
          c2[in_item.row_index] = in_item.slope_quadratic;
          c3[in_item.row_index] = in_item.slope_cubic;
        end else begin
          expected_flux.push_back(eval_curve(in_item.wave));
        end
      end
      if (out_pop && !out_empty) begin
        out_taken = 1;
        if (expected_flux.size() == 0) begin
          $display("%0t: unexpected result flux=%h sat=%b", $time,
                   out_item.flux, out_item.saturated);
          errors++;
        end else begin
          exp_r = expected_flux.pop_front();
          if (out_item.flux !== exp_r.flux) begin
            $display("%0t: flux expected %h actual %h", $time, exp_r.flux,
                     out_item.flux);
            errors++;
          end
          if (out_item.saturated !== exp_r.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time,
                     exp_r.saturated, out_item.saturated);
            errors++;
          end
        end
      end
      if (in_taken || out_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[poly_or_spline_fit_evaluator_unit] ERROR");
        $finish;
      end
    end
  end

  // item driver
  always @(negedge clk) begin
    logic nxt;
    nxt = in_push;
    if (in_taken) begin
      in_taken = 0;
      void'(pending_items.pop_front());
      nxt = 1'b0;
      send_gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 8);
    end
    if (!nxt && rst_n) begin
      if (send_gap > 0) send_gap--;
      else if (pending_items.size() > 0) begin
        in_item <= pending_items[0];
        nxt = 1'b1;
      end
    end
    in_push <= nxt;
  end

  // result sink
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 0;
      pop_gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 8);
    end
    if (pop_gap > 0) begin
      pop_gap--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= rst_n;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      psfe_pkg::CFG_FIT_MODE:    mode_r = val[0];
      psfe_pkg::CFG_POLY_DEGREE: degree_r = val[3:0];
      psfe_pkg::CFG_KNOT_COUNT:  knots_r = val[6:0];
      psfe_pkg::CFG_INV_MEAN:    inv_mean_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_push || expected_flux.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'sh7FFFFFFF;
      2:       return 32'sh80000000;
      default: return $signed($urandom()) >>> $urandom_range(4, 16);
    endcase
  endfunction

  function automatic psfe_pkg::in_item_t row_load(int row, logic signed [31:0] knot);
    psfe_pkg::in_item_t it;
    it = '0;
    it.operation = 1'(psfe_pkg::OP_LOAD);
    it.row_index = 6'(row);
    it.knot_position = knot;
    it.knot_value = rand_coef();
    it.slope_linear = rand_coef();
    it.slope_quadratic = rand_coef();
    it.slope_cubic = rand_coef();
    it.wave = 24'($urandom());
    return it;
  endfunction

  // ascending knots from -1.0 in steps of 1/16
  function automatic logic signed [31:0] knot_at(int row);
    return -32'sh10000000 + row * 32'sh01000000 + $urandom_range(0, 32'hFFFFF);
  endfunction

  function automatic psfe_pkg::in_item_t eval_item(logic [23:0] wave);
    psfe_pkg::in_item_t it;
    it = '0;
    it.operation = 1'(psfe_pkg::OP_EVAL);
    it.wave = wave;
    {it.knot_position, it.knot_value, it.slope_linear} = {$urandom(), $urandom(),
                                                          $urandom()};
    return it;
  endfunction

  function automatic logic [23:0] rand_wave();
    case ($urandom_range(0, 3))
      0:       return 24'($urandom());
      1:       return 24'(24'd1280000 + $urandom_range(0, 24'h1FFFFF) - 24'hFFFFF);
      default: return 24'($urandom_range(24'h080000, 24'h200000));
    endcase
  endfunction

  logic [31:0] phase_cfg [10][4] = '{
    '{0, 0,   2, 32'd220000000},
    '{0, 15,  2, 32'hFFFFFFFF},
    '{0, 3,   2, 32'd0},
    '{1, 0,   0, 32'd220000000},
    '{1, 0,   1, 32'd150000000},
    '{1, 0, 127, 32'd220000000},
    '{1, 0,  64, 32'd300000000},
    '{1, 0,   2, 32'hFFFFFFFF},
    '{0, 7,  33, 32'd400000000},
    '{1, 0,  17, 32'd220000000}
  };

  initial begin
    psfe_pkg::in_item_t it;
    mode_r = 0;
    degree_r = 0;
    knots_r = 2;
    inv_mean_r = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every row is written before anything reads it
    for (int r = 0; r < N_ROWS; r++) pending_items.push_back(row_load(r, knot_at(r)));
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      for (int i = 0; i < 4; i++) write_reg(2'(i), phase_cfg[ph][i]);
      if (ph == 0 || ph == 3) begin
        pending_items.push_back(eval_item(24'h000000));
        pending_items.push_back(eval_item(24'hFFFFFF));
        it = row_load(1, 32'sh80000000);
        {it.knot_value, it.slope_linear, it.slope_quadratic, it.slope_cubic} =
          {4{32'h80000000}};
        pending_items.push_back(it);
        pending_items.push_back(eval_item(24'd1280000));
        pending_items.push_back(eval_item(24'hFFFFFF));
        it = row_load(1, 32'sh7FFFFFFF);
        {it.knot_value, it.slope_linear, it.slope_quadratic, it.slope_cubic} =
          {4{32'h7FFFFFFF}};
        pending_items.push_back(it);
        pending_items.push_back(eval_item(24'd1280000));
        pending_items.push_back(eval_item(24'hFFFFFF));
        pending_items.push_back(eval_item(24'd0));
        pending_items.push_back(row_load(1, knot_at(1)));
        pending_items.push_back(row_load(0, 32'sh7FFFFFFF));
        pending_items.push_back(eval_item(24'd1280000));
        pending_items.push_back(row_load(0, knot_at(0)));
        pending_items.push_back(eval_item(24'd1000));
      end
      for (int i = 0; i < 31; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          it = row_load($urandom_range(0, N_ROWS - 1), 0);
          it.knot_position = ($urandom_range(0, 9) == 0) ? $urandom()
                                                         : knot_at(it.row_index);
          pending_items.push_back(it);
        end else begin
          pending_items.push_back(eval_item(rand_wave()));
        end
        // sender holds off until every result is back
        if (ph == 5 && i == 20) begin
          while (pending_items.size() > 0 || in_push || expected_flux.size() > 0)
            @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) $display("[poly_or_spline_fit_evaluator_unit] OK");
    else $display("[poly_or_spline_fit_evaluator_unit] ERROR");
    $finish;
  end

endmodule

// ===== poly_or_spline_fit_evaluator_unit.f =====
rtl/core/psfe_pkg.sv
rtl/core/psfe_front.sv
rtl/core/psfe_queue.sv
rtl/core/psfe_back.sv
rtl/core/poly_or_spline_fit_evaluator_unit.sv
bench/tb_top.sv
